>>> rtl/mcop_pkg.sv
// Shared types and constants of the chunk offset patcher.
package mcop_pkg;

	localparam logic [31:0] CODE_STCO    = 32'h7374636F;
	localparam logic [31:0] CODE_CO64    = 32'h636F3634;
	localparam logic [31:0] HSIZE_RESET  = 32'd8;
	localparam logic [3:0]  NARROW_BYTES = 4'd4;
	localparam logic [3:0]  WIDE_BYTES   = 4'd8;
	localparam logic [3:0]  PREFIX_BYTES = 4'd8;

	typedef enum logic [2:0] {
		MODE_SEARCH  = 3'b001,
		MODE_COUNT   = 3'b010,
		MODE_ENTRIES = 3'b100
	} mcop_mode_t;

	// One run of output words caused by one input word, right aligned in data.
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        patched;
		logic        eoh;
		logic        err;
	} mcop_run_t;

endpackage

>>> rtl/mcop_if.sv
// Channel interfaces: header bytes in, result words out.
interface mcop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_header;

	modport source(output valid, data_byte, end_of_header, input ready);
	modport sink(input valid, data_byte, end_of_header, output ready);
endinterface

interface mcop_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_last;
	logic       was_patched;
	logic       size_error;

	modport source(output valid, out_byte, run_last, stream_last, was_patched, size_error,
		input ready);
	modport sink(input valid, out_byte, run_last, stream_last, was_patched, size_error,
		output ready);
endinterface

>>> rtl/mcop_front.sv
// Front end: byte parser, atom search and entry patching, one byte per cycle while the run queue is not full.
module mcop_front #(
	parameter int POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	mcop_in_if.sink              stream,
	input  logic                 q_full,
	output logic                 push,
	output mcop_pkg::mcop_run_t  run
);

	localparam int PB = POSITION_BITS;
	localparam logic [PB-1:0] POS_MAX    = {PB{1'b1}};
	localparam logic [PB-1:0] RESUME_RST = PB'(4);
	localparam logic [PB-1:0] POS_SEVEN  = PB'(7);

	logic [31:0]          hsize_q;
	logic [PB-1:0]        pos_q;
	logic [63:0]          hist_q;
	mcop_pkg::mcop_mode_t mode_q;
	logic [31:0]          atom_end_q;
	logic [PB-1:0]        resume_q;
	logic [31:0]          left_q;
	logic [63:0]          accum_q;
	logic [3:0]           ebc_q;
	logic                 wide_q;
	logic                 err_q;

	logic                 acc;
	logic [7:0]           b;
	logic                 eoh;
	logic [63:0]          hist_n;
	logic [63:0]          accum_n;
	logic [3:0]           ebc_inc;
	logic [3:0]           esize;
	logic [63:0]          sum;
	logic [31:0]          code;
	logic [PB-1:0]        idx_i;
	logic [32:0]          pos_p1;
	logic [32:0]          end33;
	logic [32:0]          end_p1;
	logic                 hit;
	logic                 err_set;
	logic [32:0]          diff;
	logic [31:0]          room;
	logic [31:0]          left_n;

	assign acc          = stream.valid & stream.ready;
	assign stream.ready = ~q_full;
	assign b            = stream.data_byte;
	assign eoh          = stream.end_of_header;

	assign hist_n  = {hist_q[55:0], b};
	assign accum_n = {accum_q[55:0], b};
	assign ebc_inc = ebc_q + 4'd1;
	assign esize   = wide_q ? mcop_pkg::WIDE_BYTES : mcop_pkg::NARROW_BYTES;
	assign sum     = accum_n + {32'd0, hsize_q};

	// search: type code sits at the last four bytes, i = p - 3, i + 4 = p + 1
	assign code   = hist_n[31:0];
	assign idx_i  = pos_q - PB'(3);
	assign pos_p1 = 33'(pos_q) + 33'd1;
	assign end33  = 33'(pos_q - POS_SEVEN) + {1'b0, hist_n[63:32]};
	assign end_p1 = end33 + 33'd1;
	assign hit    = (mode_q == mcop_pkg::MODE_SEARCH) && !err_q && (pos_q >= POS_SEVEN)
		&& (idx_i >= resume_q) && (pos_p1 < {1'b0, hsize_q})
		&& ((code == mcop_pkg::CODE_STCO) || (code == mcop_pkg::CODE_CO64));
	assign err_set = hit && (end33 > {1'b0, hsize_q});

	// entry room up to the atom end; first entry byte is p + 1
	assign diff   = {1'b0, atom_end_q} - pos_p1;
	assign room   = ({1'b0, atom_end_q} > pos_p1) ?
		(wide_q ? {2'b00, diff[32:3]} : {1'b0, diff[32:2]}) : 32'd0;
	assign left_n = (hist_n[31:0] > room) ? room : hist_n[31:0];

	always_comb begin
		run         = '0;
		run.eoh     = eoh;
		run.err     = err_q | err_set;
		run.data    = {56'd0, b};
		run.count   = 4'd1;
		case (mode_q)
			mcop_pkg::MODE_ENTRIES: begin
				if (ebc_inc >= esize) begin
					run.data    = wide_q ? sum : {32'd0, sum[31:0]};
					run.count   = esize;
					run.patched = 1'b1;
				end else if (eoh) begin
					run.data  = accum_n;
					run.count = ebc_inc;
				end else begin
					run.count = 4'd0;
				end
			end
			default: ;
		endcase
	end

	assign push = acc && (run.count != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsize_q    <= mcop_pkg::HSIZE_RESET;
			pos_q      <= '0;
			hist_q     <= '0;
			mode_q     <= mcop_pkg::MODE_SEARCH;
			atom_end_q <= '0;
			resume_q   <= RESUME_RST;
			left_q     <= '0;
			accum_q    <= '0;
			ebc_q      <= '0;
			wide_q     <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				hsize_q <= cfg_wdata;
			end
			if (acc) begin
				hist_q <= hist_n;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + PB'(1);
				end
				case (mode_q)
					mcop_pkg::MODE_ENTRIES: begin
						if (ebc_inc >= esize) begin
							accum_q <= '0;
							ebc_q   <= '0;
							left_q  <= left_q - 32'd1;
							if (left_q == 32'd1) begin
								mode_q <= mcop_pkg::MODE_SEARCH;
							end
						end else begin
							accum_q <= accum_n;
							ebc_q   <= ebc_inc;
						end
					end
					mcop_pkg::MODE_COUNT: begin
						ebc_q <= ebc_inc;
						if (ebc_inc >= mcop_pkg::PREFIX_BYTES) begin
							left_q  <= left_n;
							ebc_q   <= '0;
							accum_q <= '0;
							mode_q  <= (left_n != 32'd0) ? mcop_pkg::MODE_ENTRIES
								: mcop_pkg::MODE_SEARCH;
						end
					end
					mcop_pkg::MODE_SEARCH: begin
						if (err_set) begin
							err_q <= 1'b1;
						end else if (hit) begin
							atom_end_q <= end33[31:0];
							resume_q   <= (end_p1 > 33'(POS_MAX)) ? POS_MAX : end_p1[PB-1:0];
							wide_q     <= (code == mcop_pkg::CODE_CO64);
							ebc_q      <= '0;
							mode_q     <= mcop_pkg::MODE_COUNT;
						end
					end
					default: mode_q <= mcop_pkg::MODE_SEARCH;
				endcase
				if (eoh) begin
					// new header follows; only the error flag and header_size survive
					pos_q      <= '0;
					hist_q     <= '0;
					mode_q     <= mcop_pkg::MODE_SEARCH;
					atom_end_q <= '0;
					resume_q   <= RESUME_RST;
					left_q     <= '0;
					accum_q    <= '0;
					ebc_q      <= '0;
					wide_q     <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/mcop_queue.sv
// Run queue between parser and serializer.
module mcop_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mcop_pkg::mcop_run_t wr_run,
	input  logic                pop,
	output mcop_pkg::mcop_run_t rd_run,
	output logic                full,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	mcop_pkg::mcop_run_t slot_q [DEPTH];
	logic [AW-1:0]       wr_q;
	logic [AW-1:0]       rd_q;
	logic [CW-1:0]       cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_run  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wr_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/mcop_back.sv
// Back end: serializes queued runs into one result word per cycle while the receiver is ready.
module mcop_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mcop_pkg::mcop_run_t head,
	input  logic                empty,
	output logic                pop,
	mcop_out_if.source          result
);

	mcop_pkg::mcop_run_t cur_q;
	logic [3:0]          rem_q;
	logic [2:0]          sel;

	assign sel = 3'(rem_q - 4'd1);
	assign pop = !empty && ((rem_q == 4'd0) || ((rem_q == 4'd1) && result.ready));

	assign result.valid       = (rem_q != 4'd0);
	assign result.out_byte    = cur_q.data[{sel, 3'b000} +: 8];
	assign result.run_last    = (rem_q == 4'd1);
	assign result.stream_last = (rem_q == 4'd1) && cur_q.eoh;
	assign result.was_patched = cur_q.patched;
	assign result.size_error  = cur_q.err;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= head.count;
		end else if (result.valid && result.ready) begin
			rem_q <= rem_q - 4'd1;
		end
	end

endmodule

>>> rtl/mp4_chunk_offset_patcher.sv
// Chunk offset patcher for a movie header atom: top level.
//
// stream carries one header byte per word with end_of_header on the last byte.
// result carries one byte per word: passed through or, inside an 'stco' or
// 'co64' table, a chunk offset with header_size added. A table entry is held
// until its last byte arrives and then leaves as a run of 4 or 8 words.
// cfg_we/cfg_wdata write header_size (reset 8); the user must do so only while
// the block is idle, which the block does not enforce. Throughput: one input
// byte per cycle and one result word per cycle. The parser takes a byte each
// cycle the run queue is not full; the serializer drains the queue one word
// per cycle while the receiver is ready. An accepted byte reaches its first
// result word through a queue slot and then the serializer register.
// A stalled receiver holds the current word; input keeps being taken until
// the queue fills (QUEUE_DEPTH runs), then stream.ready drops.
// Reset clears all parse state and the sticky size error; header_size
// returns to 8. After end_of_header all but the error and header_size restarts.
module mp4_chunk_offset_patcher #(
	parameter int POSITION_BITS = 32,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	mcop_in_if.sink     stream,
	mcop_out_if.source  result
);

	mcop_pkg::mcop_run_t wr_run;
	mcop_pkg::mcop_run_t head;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	mcop_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.stream   (stream),
		.q_full   (full),
		.push     (push),
		.run      (wr_run)
	);

	mcop_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_run(wr_run),
		.pop   (pop),
		.rd_run(head),
		.full  (full),
		.empty (empty)
	);

	mcop_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

endmodule

>>> rtl/mcop_chk.sv
// Port-level checks for the chunk offset patcher, bound to the top level.
module mcop_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       stream_last,
	input logic       size_error
);

	// end of header always closes a run
	a_stream_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_last |-> run_last)
		else $error("stream_last without run_last");

	// error flag is sticky until reset
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && size_error) ##1 out_valid |-> size_error)
		else $error("size_error dropped");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("result word changed while stalled");

endmodule

bind mp4_chunk_offset_patcher mcop_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_byte   (result.out_byte),
	.run_last   (result.run_last),
	.stream_last(result.stream_last),
	.size_error (result.size_error)
);
